FILE: sv/sorted_key_value_table_core_assert.svh
// assertion macros for the sorted key/value table core and its checker
// needs nothing else; included by sv/skvt_checker.sv
`ifndef SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// property that holds in the same cycle
`define SKVT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that holds in the next cycle
`define SKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/skvt_pkg.sv
// shared constants for the sorted key/value table core
// no dependencies; used by the core and its checker
package skvt_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 2);

    localparam int OPC_W    = 2;
    localparam int CODE_W   = 21;
    localparam int GLYPH_W  = 16;
    localparam int POS_W    = 9;
    localparam int STAT_W   = 2;

    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int ENTRY_W  = CODE_W + GLYPH_W;

    localparam int IN_BITS  = CODE_W + GLYPH_W + POS_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + GLYPH_W + POS_W + STAT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // output request bit positions
    localparam int O_FOUND  = 0;
    localparam int O_GLYPH  = 1;
    localparam int O_POS    = O_GLYPH + GLYPH_W;
    localparam int O_STAT   = O_POS + POS_W;

    localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

endpackage

FILE: sv/sorted_key_value_table_core.sv
// sorted key/value table core: sorted code to glyph map in one synchronous memory
// depends on skvt_pkg
//
// input channel (i_s_*): one command per request, opcode in tuser, code, glyph and
// one-based insert slot in tdata. output channel (o_m_*): one result per command.
// a lookup binary-searches the memory, each probe a read and then a compare on
// the registered read data. an insert reads the neighbours of its slot, then
// moves every later entry up one place at one entry per cycle through the
// single read and write port, then writes the new entry. clear, unused opcodes
// and inserts refused for a full table or a bad slot go straight to the result;
// an insert refused for its order is refused once its neighbours have been read.
// one command is worked on at a time; o_s_tready is high only while idle.
// the result sits in an output register, so the next command is taken while it
// waits; a stalled receiver only holds the block once a second result is ready.
// reset empties the table at once (entry count to zero, no clearing pass) and
// drops any result not yet taken.
module sorted_key_value_table_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [skvt_pkg::IN_W-1:0] i_s_tdata,   // char_code, glyph_in, insert_position
    input  logic [skvt_pkg::OPC_W-1:0] i_s_tuser,  // opcode
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [skvt_pkg::OUT_W-1:0] o_m_tdata   // found, glyph_out, position, status
);
    import skvt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SRCH   = 9'b000000010,
        S_CMP    = 9'b000000100,
        S_CHKLO  = 9'b000001000,
        S_CHKHI  = 9'b000010000,
        S_CHKEND = 9'b000100000,
        S_SHIFT  = 9'b001000000,
        S_PUT    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [ENTRY_W-1:0] r_mem [CAPACITY];
    logic [ENTRY_W-1:0] r_rdata;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic [CODE_W-1:0]  r_code, n_code;
    logic [GLYPH_W-1:0] r_glyph, n_glyph;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [ADDR_W-1:0]  r_mid, n_mid;
    logic               r_hit, n_hit;
    logic [GLYPH_W-1:0] r_hglyph, n_hglyph;
    logic               r_bad, n_bad;
    logic [ADDR_W-1:0]  r_j, n_j;
    logic [ADDR_W-1:0]  r_wa, n_wa;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_pend, n_pend;
    logic               r_rfound, n_rfound;
    logic [GLYPH_W-1:0] r_rglyph, n_rglyph;
    logic [POS_W-1:0]   r_rpos, n_rpos;
    logic [STAT_W-1:0]  r_rstat, n_rstat;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;

    logic [CODE_W-1:0]  in_code;
    logic [GLYPH_W-1:0] in_glyph;
    logic [POS_W-1:0]   in_pos;
    logic [CMP_W-1:0]   mid_sum;
    logic [CMP_W-1:0]   pos_m1;
    logic [CMP_W-1:0]   cnt_m1;
    logic [CMP_W-1:0]   lo_p1;
    logic [CMP_W-1:0]   k_ext;
    logic [ADDR_W-1:0]  k_idx;
    logic [CODE_W-1:0]  rd_key;
    logic [GLYPH_W-1:0] rd_glyph;

    assign in_code  = i_s_tdata[CODE_W-1:0];
    assign in_glyph = i_s_tdata[CODE_W +: GLYPH_W];
    assign in_pos   = i_s_tdata[CODE_W + GLYPH_W +: POS_W];

    assign rd_key   = r_rdata[ENTRY_W-1 -: CODE_W];
    assign rd_glyph = r_rdata[GLYPH_W-1:0];

    assign mid_sum  = (CMP_W'(r_lo) + CMP_W'(r_hi)) >> 1;
    assign pos_m1   = CMP_W'(r_pos) - CMP_W'(1);
    assign cnt_m1   = CMP_W'(r_count) - CMP_W'(1);
    assign lo_p1    = CMP_W'(r_lo) + CMP_W'(1);
    assign k_ext    = pos_m1;
    assign k_idx    = pos_m1[ADDR_W-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_glyph     = r_glyph;
        n_pos       = r_pos;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_hit       = r_hit;
        n_hglyph    = r_hglyph;
        n_bad       = r_bad;
        n_j         = r_j;
        n_wa        = r_wa;
        n_left      = r_left;
        n_pend      = r_pend;
        n_rfound    = r_rfound;
        n_rglyph    = r_rglyph;
        n_rpos      = r_rpos;
        n_rstat     = r_rstat;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_wa;
        mem_wdata   = r_rdata;
        mem_raddr   = r_mid;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_code   = in_code;
                    n_glyph  = in_glyph;
                    n_pos    = in_pos;
                    n_rfound = 1'b0;
                    n_rglyph = '0;
                    n_rpos   = '0;
                    n_rstat  = ST_OK;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_hit    = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_s_tuser)
                        OP_LOOKUP: n_state = S_SRCH;
                        OP_INSERT: begin
                            if (CMP_W'(r_count) >= CMP_W'(CAPACITY)) begin
                                n_rstat = ST_FULL;
                            end else if (in_pos == '0 ||
                                         CMP_W'(in_pos) > CMP_W'(r_count) + CMP_W'(1)) begin
                                n_rstat = ST_BAD;
                            end else begin
                                n_state = S_CHKLO;
                            end
                        end
                        OP_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            S_SRCH: begin
                if (r_lo == r_hi) begin
                    n_rfound = r_hit;
                    n_rglyph = r_hit ? r_hglyph : '0;
                    n_rpos   = lo_p1[POS_W-1:0];
                    n_state  = S_DONE;
                end else begin
                    mem_raddr = mid_sum[ADDR_W-1:0];
                    n_mid     = mid_sum[ADDR_W-1:0];
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_key < r_code) begin
                    n_lo = CNT_W'(CMP_W'(r_mid) + CMP_W'(1));
                end else begin
                    n_hi     = CNT_W'(r_mid);
                    n_hit    = (rd_key == r_code);
                    n_hglyph = rd_glyph;
                end
                n_state = S_SRCH;
            end
            S_CHKLO: begin
                mem_raddr = k_idx - ADDR_W'(1);
                n_state   = S_CHKHI;
            end
            S_CHKHI: begin
                n_bad     = (k_ext != '0) && !(rd_key < r_code);
                mem_raddr = k_idx;
                n_state   = S_CHKEND;
            end
            S_CHKEND: begin
                if (r_bad || ((k_ext < CMP_W'(r_count)) && !(r_code < rd_key))) begin
                    n_rstat = ST_BAD;
                    n_state = S_DONE;
                end else if (k_ext < CMP_W'(r_count)) begin
                    n_j     = cnt_m1[ADDR_W-1:0];
                    n_left  = CNT_W'(CMP_W'(r_count) - k_ext);
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wa;
                    mem_wdata = r_rdata;
                end
                if (r_left != '0) begin
                    mem_raddr = r_j;
                    n_wa      = r_j + ADDR_W'(1);
                    n_j       = r_j - ADDR_W'(1);
                    n_left    = r_left - CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = k_idx;
                mem_wdata = {r_code, r_glyph};
                n_count   = r_count + CNT_W'(1);
                n_rpos    = r_pos;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_W'({r_rstat, r_rpos, r_rglyph, r_rfound});
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_glyph    <= n_glyph;
        r_pos      <= n_pos;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_hit      <= n_hit;
        r_hglyph   <= n_hglyph;
        r_bad      <= n_bad;
        r_j        <= n_j;
        r_wa       <= n_wa;
        r_left     <= n_left;
        r_rfound   <= n_rfound;
        r_rglyph   <= n_rglyph;
        r_rpos     <= n_rpos;
        r_rstat    <= n_rstat;
        r_out_data <= n_out_data;
    end

endmodule

FILE: sv/skvt_checker.sv
// port-level checks for the sorted key/value table core, bound to the top level
// depends on skvt_pkg and sorted_key_value_table_core_assert.svh
`include "sorted_key_value_table_core_assert.svh"

module skvt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [skvt_pkg::OUT_W-1:0] o_m_tdata
);
    import skvt_pkg::*;

    logic               res_found;
    logic [GLYPH_W-1:0] res_glyph;
    logic [POS_W-1:0]   res_pos;
    logic [STAT_W-1:0]  res_stat;

    assign res_found = o_m_tdata[O_FOUND];
    assign res_glyph = o_m_tdata[O_GLYPH +: GLYPH_W];
    assign res_pos   = o_m_tdata[O_POS +: POS_W];
    assign res_stat  = o_m_tdata[O_STAT +: STAT_W];

    // a stalled result stays offered
    `SKVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")
    // one request at a time
    `SKVT_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")
    // a hit is a clean lookup at a real slot
    `SKVT_ASSERT_NOW(a_hit_ok, i_clk, i_rst_n, o_m_tvalid && res_found, res_stat == ST_OK && res_pos != '0, "hit with error or slot zero")
    // a refused insert reports nothing else
    `SKVT_ASSERT_NOW(a_err_clean, i_clk, i_rst_n, o_m_tvalid && res_stat != ST_OK, !res_found && res_pos == '0 && res_glyph == '0, "refused insert with payload")
    // glyph only on a hit
    `SKVT_ASSERT_NOW(a_glyph_hit, i_clk, i_rst_n, o_m_tvalid && !res_found, res_glyph == '0, "glyph without hit")

endmodule

bind sorted_key_value_table_core skvt_checker u_skvt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/tb_sorted_key_value_table_core.sv
// testbench for sorted_key_value_table_core: directed, full-table and random command runs
// checked against an in-bench model of the sorted code/glyph table
// depends on skvt_pkg and sv/sorted_key_value_table_core.sv
`timescale 1ns / 1ps

module tb_sorted_key_value_table_core;
    import skvt_pkg::*;

    localparam logic [OPC_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [CODE_W-1:0]  CODE_MAX  = 21'h10FFFF;
    localparam logic [GLYPH_W-1:0] GLYPH_MAX = 16'hFFFF;
    localparam int RANDOM_COMMANDS = 760;

    typedef struct packed {
        logic               found;
        logic [GLYPH_W-1:0] glyph;
        logic [POS_W-1:0]   position;
        logic [STAT_W-1:0]  status;
    } t_table_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_W-1:0]    i_s_tdata;
    logic [OPC_W-1:0]   i_s_tuser;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;

    logic [CODE_W-1:0]  table_keys   [CAPACITY];
    logic [GLYPH_W-1:0] table_glyphs [CAPACITY];
    int                 table_count;

    t_table_answer      pending_answers [$];
    int                 error_count;
    int                 burst_left;

    sorted_key_value_table_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** sorted_key_value_table_core: FAILED **");
        $finish;
    end

    // one-based slot of the first stored code not below the given one
    function automatic int locate_code(input logic [CODE_W-1:0] code, output bit hit);
        hit = 1'b0;
        for (int i = 0; i < table_count; i++) begin
            if (code <= table_keys[i]) begin
                hit = (code == table_keys[i]);
                return i + 1;
            end
        end
        return table_count + 1;
    endfunction

    function automatic t_table_answer apply_command(input logic [OPC_W-1:0] op,
                                                    input logic [CODE_W-1:0] code,
                                                    input logic [GLYPH_W-1:0] glyph,
                                                    input logic [POS_W-1:0] pos);
        t_table_answer ans;
        bit            hit;
        int            slot;
        int            k;
        ans = '0;
        case (op)
            OP_LOOKUP: begin
                slot = locate_code(code, hit);
                ans.found    = hit;
                ans.position = POS_W'(slot);
                if (hit)
                    ans.glyph = table_glyphs[slot-1];
            end
            OP_INSERT: begin
                k = int'(pos) - 1;
                if (table_count >= CAPACITY) begin
                    ans.status = ST_FULL;
                end else if (pos < 1 || pos > table_count + 1) begin
                    ans.status = ST_BAD;
                end else if ((k > 0 && table_keys[k-1] >= code)
                             || (k < table_count && code >= table_keys[k])) begin
                    ans.status = ST_BAD;
                end else begin
                    for (int i = table_count; i > k; i--) begin
                        table_keys[i]   = table_keys[i-1];
                        table_glyphs[i] = table_glyphs[i-1];
                    end
                    table_keys[k]   = code;
                    table_glyphs[k] = glyph;
                    table_count++;
                    ans.position = pos;
                end
            end
            OP_CLEAR: begin
                table_count = 0;
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic send_command(input logic [OPC_W-1:0] op, input logic [CODE_W-1:0] code,
                                input logic [GLYPH_W-1:0] glyph, input logic [POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(IN_W-IN_BITS){1'b0}}, pos, glyph, code};
        pending_answers.push_back(apply_command(op, code, glyph, pos));
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
    endtask

    task automatic check_answer();
        t_table_answer want;
        t_table_answer got;
        got.found    = o_m_tdata[O_FOUND];
        got.glyph    = o_m_tdata[O_GLYPH +: GLYPH_W];
        got.position = o_m_tdata[O_POS +: POS_W];
        got.status   = o_m_tdata[O_STAT +: STAT_W];
        if (pending_answers.size() == 0) begin
            $error("unexpected result request: tdata %h", o_m_tdata);
            error_count++;
        end else begin
            want = pending_answers.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                error_count++;
            end
            if (got.glyph !== want.glyph) begin
                $error("glyph_out: expected %0d, actual %0d", want.glyph, got.glyph);
                error_count++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                error_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                error_count++;
            end
        end
    endtask

    // receiver with its own rotating stall pattern, reloaded with all ones or a random value
    initial begin
        logic [15:0] stall_pattern;
        int          cycle_no;
        stall_pattern = 16'hFFFF;
        cycle_no      = 0;
        i_m_tready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                check_answer();
            cycle_no++;
            if (cycle_no % 256 == 0)
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            i_m_tready <= stall_pattern[0];
        end
    end

    task automatic test_directed();
        send_command(OP_LOOKUP, '0, '0, '0);
        send_command(OP_INSERT, 21'd9, 16'd1, 9'd0);
        send_command(OP_INSERT, 21'd9, 16'd1, 9'd2);
        send_command(OP_INSERT, CODE_MAX, GLYPH_MAX, 9'd1);
        send_command(OP_INSERT, '0, '0, 9'd1);
        send_command(OP_INSERT, 21'd5, 16'd3, 9'd1);
        send_command(OP_INSERT, '0, 16'd3, 9'd2);
        send_command(OP_INSERT, CODE_MAX, 16'd3, 9'd3);
        send_command(OP_LOOKUP, '0, '0, '0);
        send_command(OP_LOOKUP, CODE_MAX, '0, '0);
        send_command(OP_LOOKUP, 21'd7, '0, '0);
        send_command(OP_INSERT, 21'd7, 16'h5A5A, 9'd2);
        send_command(OP_LOOKUP, 21'd7, '0, '0);
        send_command(OP_LOOKUP, CODE_MAX - CODE_W'(1), '0, '0);
        send_command(OP_INSERT, 21'd100, 16'hA5A5, 9'd511);
        send_command(OP_UNUSED, '1, '1, '1);
        send_command(OP_CLEAR, '1, '1, '1);
        send_command(OP_LOOKUP, 21'd7, '0, '0);
        send_command(OP_INSERT, 21'd7, 16'd2, 9'd2);
        send_command(OP_INSERT, 21'd7, 16'd2, 9'd1);
        send_command(OP_LOOKUP, 21'd7, '0, '0);
    endtask

    task automatic test_full_table();
        send_command(OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < CAPACITY; i++)
            send_command(OP_INSERT, CODE_W'(i * 4352 + $urandom_range(0, 4351)),
                         16'($urandom), POS_W'(i + 1));
        send_command(OP_INSERT, 21'd1, 16'd1, 9'd1);
        send_command(OP_INSERT, 21'd1, 16'd1, 9'd0);
        send_command(OP_INSERT, CODE_MAX, 16'd1, 9'd257);
        send_command(OP_LOOKUP, table_keys[$urandom_range(0, CAPACITY - 1)], '0, '0);
        send_command(OP_LOOKUP, CODE_MAX, '0, '0);
        send_command(OP_LOOKUP, '0, '0, '0);
        send_command(OP_CLEAR, '0, '0, '0);
    endtask

    task automatic test_random();
        int                 pick;
        int                 slot;
        bit                 hit;
        logic [CODE_W-1:0]  code;
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            pick = $urandom_range(0, 99);
            code = CODE_W'($urandom_range(0, 1114111));
            if (pick < 35 && table_count > 0) begin
                send_command(OP_LOOKUP, table_keys[$urandom_range(0, table_count - 1)],
                             16'($urandom), 9'($urandom));
            end else if (pick < 55) begin
                send_command(OP_LOOKUP, code, 16'($urandom), 9'($urandom));
            end else if (pick < 87) begin
                // lookup-guided insert at the slot the table would choose
                slot = locate_code(code, hit);
                send_command(OP_INSERT, code, 16'($urandom), POS_W'(slot));
            end else if (pick < 96) begin
                send_command(OP_INSERT, code, 16'($urandom), 9'($urandom));
            end else if (pick < 98) begin
                send_command(OP_UNUSED, code, 16'($urandom), 9'($urandom));
            end else begin
                send_command(OP_CLEAR, code, 16'($urandom), 9'($urandom));
            end
        end
    endtask

    initial begin
        error_count  = 0;
        burst_left   = 0;
        table_count  = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= OP_LOOKUP;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_random();

        i_s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (error_count == 0)
            $display("** sorted_key_value_table_core: PASSED **");
        else
            $display("** sorted_key_value_table_core: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/skvt_pkg.sv
sv/sorted_key_value_table_core.sv
sv/skvt_checker.sv
tb/tb_sorted_key_value_table_core.sv
